// ----- hdl/sab_pkg.sv -----
package sab_pkg;

  // Store geometry. The bitmap is kept as rows of ROW_BITS flags each.
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int COUNT_W    = SLOT_W + 1;
  localparam int ROW_BITS   = 8;
  localparam int ROW_SEL_W  = $clog2(ROW_BITS);
  localparam int ROWS       = CAPACITY / ROW_BITS;
  localparam int ROW_IDX_W  = $clog2(ROWS);

  // Transaction field widths.
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int RUN_W      = 9;
  localparam int SUM_W      = RUN_W + 1;
  localparam int POP_W      = $clog2(ROW_BITS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_DATA,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] addr;
    logic [ROW_BITS-1:0]  wdata;
  } bm_req_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_W-1:0]     raddr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
  } dm_req_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [OUT_DATA_W-1:0] read_data;
    logic [COUNT_W-1:0]    occupied_count;
  } result_t;

endpackage

// ----- hdl/sab_if.sv -----
interface sab_in_if import sab_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [IN_DATA_W-1:0] write_data;
  logic [SLOT_W-1:0]    slot_index;
  logic [RUN_W-1:0]     run_length;
  logic                 search_from_start;

  modport source (
    output valid, op, write_data, slot_index, run_length, search_from_start,
    input  ready
  );
  modport sink (
    input  valid, op, write_data, slot_index, run_length, search_from_start,
    output ready
  );
endinterface

interface sab_out_if import sab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot;
  logic [OUT_DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]    occupied_count;

  modport source (
    output valid, status, slot, read_data, occupied_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot, read_data, occupied_count,
    output ready
  );
endinterface

// ----- hdl/sab_ram.sv -----
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sab_bitmap.sv -----
module sab_bitmap import sab_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bm_req_t             req,
  output logic [ROW_BITS-1:0] rdata
);

  // One valid flag per row: a row never written reads as all free.
  logic [ROWS-1:0]     valid_r;
  logic [ROWS-1:0]     valid_nxt;
  logic                hit_r;
  logic [ROW_BITS-1:0] ram_q;

  sab_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.addr),
    .wdata (req.wdata),
    .re    (req.rd_en),
    .raddr (req.addr),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (req.wr_en) begin
      valid_nxt[req.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      hit_r <= valid_r[req.addr];
    end
  end

  assign rdata = hit_r ? ram_q : '0;

endmodule

// ----- hdl/sab_ctrl.sv -----
module sab_ctrl import sab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sab_in_if.sink                in_chan,
  output bm_req_t               bm_req,
  input  logic [ROW_BITS-1:0]   bm_rdata,
  output dm_req_t               dm_req,
  input  logic [DATA_WIDTH-1:0] dm_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  function automatic logic [POP_W-1:0] pop_count(input logic [ROW_BITS-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      n = n + POP_W'(v[b]);
    end
    return n;
  endfunction

  function automatic logic [ROW_SEL_W-1:0] lowest_set(input logic [ROW_BITS-1:0] v);
    logic [ROW_SEL_W-1:0] k;
    k = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        k = ROW_SEL_W'(b);
      end
    end
    return k;
  endfunction

  state_t               state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [SLOT_W-1:0]    base_r, base_nxt;
  logic [SLOT_W-1:0]    end_r, end_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [SLOT_W-1:0]    hint_r, hint_nxt;
  logic                 hint_full_r, hint_full_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  status_t              status_r, status_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;

  logic                 in_ready;
  logic                 in_fire;
  logic [SUM_W-1:0]     rm_sum;
  logic                 rm_bad;
  logic [COUNT_W-1:0]   find_start;
  logic                 go_walk;

  logic                 first_row;
  logic                 last_row;
  logic                 at_end;
  logic [ROW_SEL_W-1:0] lo;
  logic [ROW_SEL_W-1:0] hi;
  logic [ROW_BITS-1:0]  lo_mask;
  logic [ROW_BITS-1:0]  rm_mask;
  logic [ROW_BITS-1:0]  set_row;
  logic [ROW_BITS-1:0]  search_vec;
  logic                 found;
  logic [ROW_SEL_W-1:0] found_idx;
  logic [SLOT_W-1:0]    found_slot;

  assign in_fire = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // Decode of an arriving transaction.
  always_comb begin
    rm_sum     = SUM_W'(in_chan.slot_index) + SUM_W'(in_chan.run_length);
    rm_bad     = rm_sum > SUM_W'(CAPACITY);
    find_start = in_chan.search_from_start ? '0
               : COUNT_W'(in_chan.slot_index) + COUNT_W'(1);
    unique case (in_chan.op)
      OP_INSERT: go_walk = !hint_full_r;
      OP_REMOVE: go_walk = !rm_bad && (in_chan.run_length != '0);
      OP_FIND:   go_walk = !find_start[SLOT_W];
      default:   go_walk = 1'b0;
    endcase
  end

  // Row processing while the bitmap row is on the read port.
  always_comb begin
    first_row  = row_r == base_r[SLOT_W-1:ROW_SEL_W];
    last_row   = row_r == end_r[SLOT_W-1:ROW_SEL_W];
    at_end     = row_r == ROW_IDX_W'(ROWS - 1);
    lo         = first_row ? base_r[ROW_SEL_W-1:0] : '0;
    hi         = last_row ? end_r[ROW_SEL_W-1:0] : ROW_SEL_W'(ROW_BITS - 1);
    lo_mask    = {ROW_BITS{1'b1}} << lo;
    rm_mask    = lo_mask & ({ROW_BITS{1'b1}} >> (ROW_SEL_W'(ROW_BITS - 1) - hi));
    set_row    = first_row ? (bm_rdata | (ROW_BITS'(1) << lo)) : bm_rdata;
    search_vec = (op_r == OP_INSERT) ? (~set_row & lo_mask) : (bm_rdata & lo_mask);
    found      = |search_vec;
    found_idx  = lowest_set(search_vec);
    found_slot = {row_r, found_idx};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = go_walk ? S_RD : S_RESP;
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        unique case (op_r)
          OP_INSERT: state_nxt = (found || at_end) ? S_RESP : S_RD;
          OP_REMOVE: state_nxt = last_row ? S_RESP : S_RD;
          OP_FIND:   state_nxt = found ? S_DATA : (at_end ? S_RESP : S_RD);
          default:   state_nxt = S_RESP;
        endcase
      end
      S_DATA: state_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready     = state_r == S_IDLE;
    res_valid    = state_r == S_RESP;
    bm_req.rd_en = state_r == S_RD;
    bm_req.wr_en = (state_r == S_EX) &&
                   ((op_r == OP_REMOVE) || ((op_r == OP_INSERT) && first_row));
    bm_req.addr  = row_r;
    bm_req.wdata = (op_r == OP_REMOVE) ? (bm_rdata & ~rm_mask) : set_row;
    dm_req.wr_en = in_fire && (in_chan.op == OP_INSERT) && !hint_full_r;
    dm_req.waddr = hint_r;
    dm_req.wdata = in_chan.write_data[DATA_WIDTH-1:0];
    dm_req.rd_en = (state_r == S_EX) && (op_r == OP_FIND) && found;
    dm_req.raddr = found_slot;
    res.status         = status_r;
    res.slot           = slot_r;
    res.read_data      = data_r;
    res.occupied_count = count_r;
  end

  // Datapath updates.
  always_comb begin
    op_nxt        = op_r;
    base_nxt      = base_r;
    end_nxt       = end_r;
    row_nxt       = row_r;
    hint_nxt      = hint_r;
    hint_full_nxt = hint_full_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    data_nxt      = data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_chan.op;
          slot_nxt   = '0;
          data_nxt   = '0;
          status_nxt = ST_OK;
          unique case (in_chan.op)
            OP_INSERT: begin
              if (hint_full_r) begin
                status_nxt = ST_FULL;
              end else begin
                slot_nxt = hint_r;
                base_nxt = hint_r;
                row_nxt  = hint_r[SLOT_W-1:ROW_SEL_W];
              end
            end
            OP_REMOVE: begin
              base_nxt = in_chan.slot_index;
              end_nxt  = SLOT_W'(rm_sum - SUM_W'(1));
              row_nxt  = in_chan.slot_index[SLOT_W-1:ROW_SEL_W];
              if (rm_bad) begin
                status_nxt = ST_RANGE;
              end else if (go_walk) begin
                // The hint moves to the run start if that lies below it or the store is full.
                if ((in_chan.slot_index < hint_r) || hint_full_r) begin
                  hint_nxt = in_chan.slot_index;
                end
                hint_full_nxt = 1'b0;
              end
            end
            OP_FIND: begin
              base_nxt = find_start[SLOT_W-1:0];
              row_nxt  = find_start[SLOT_W-1:ROW_SEL_W];
              if (!go_walk) begin
                status_nxt = ST_NONE;
              end
            end
            default: status_nxt = ST_RANGE;
          endcase
        end
      end
      S_EX: begin
        row_nxt = row_r + ROW_IDX_W'(1);
        unique case (op_r)
          OP_INSERT: begin
            if (first_row) begin
              count_nxt = count_r + COUNT_W'(1);
            end
            if (found) begin
              hint_nxt = found_slot;
            end else if (at_end) begin
              hint_full_nxt = 1'b1;
            end
          end
          OP_REMOVE: begin
            count_nxt = count_r - COUNT_W'(pop_count(bm_rdata & rm_mask));
          end
          OP_FIND: begin
            if (found) begin
              slot_nxt = found_slot;
            end else if (at_end) begin
              status_nxt = ST_NONE;
            end
          end
          default: status_nxt = ST_RANGE;
        endcase
      end
      S_DATA: data_nxt = OUT_DATA_W'(dm_rdata);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hint_r      <= '0;
      hint_full_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      hint_full_r <= hint_full_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    base_r   <= base_nxt;
    end_r    <= end_nxt;
    row_r    <= row_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    data_r   <= data_nxt;
  end

endmodule

// ----- hdl/slot_allocator_with_bitmap.sv -----
// Channel   Direction  Payload
// in_chan   sink       op, write_data, slot_index, run_length, search_from_start
// out_chan  source     status, slot, read_data, occupied_count
//
// One transaction is worked on at a time: it is accepted, then each bitmap row visited is
// read and then processed (insert from the hinted row up to the next free slot, remove over
// the rows of the run, find over the rows searched), a successful find adds a data read,
// and the result is then offered to the output register until it is taken.
// A full store, a range error, an empty remove, the unused op code and a find past the
// last slot visit no rows. The bitmap RAM has a single port and a registered read.
// Reset (rst_n, synchronous) clears the row valid flags at once; no clearing pass.
// A stalled result sits in the output register while the next transaction runs; a second
// result then waits in the sequencer, which keeps in_chan.ready low until it is taken.
module slot_allocator_with_bitmap import sab_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sab_in_if.sink    in_chan,
  sab_out_if.source out_chan
);

  // Request structs between the sequencer and the two memories.
  bm_req_t               bm_req;
  logic [ROW_BITS-1:0]   bm_rdata;
  dm_req_t               dm_req;
  logic [DATA_WIDTH-1:0] dm_rdata;

  // Result handed from the sequencer into the output register.
  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .bm_req    (bm_req),
    .bm_rdata  (bm_rdata),
    .dm_req    (dm_req),
    .dm_rdata  (dm_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Occupancy bitmap, organised as rows with a valid flag each.
  sab_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bm_req),
    .rdata (bm_rdata)
  );

  // Slot data store. Only slots that have been written are ever read back.
  sab_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (dm_req.wr_en),
    .waddr (dm_req.waddr),
    .wdata (dm_req.wdata),
    .re    (dm_req.rd_en),
    .raddr (dm_req.raddr),
    .rdata (dm_rdata)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_r.status;
  assign out_chan.slot           = out_r.slot;
  assign out_chan.read_data      = out_r.read_data;
  assign out_chan.occupied_count = out_r.occupied_count;

endmodule

// ----- tb/sv/sab_tb_pkg.sv -----
`timescale 1ns / 100ps

package sab_tb_pkg;
  import sab_pkg::*;

  // The one op code that the package enum leaves unused.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IN_DATA_W-1:0] write_data;
    logic [SLOT_W-1:0]    slot_index;
    logic [RUN_W-1:0]     run_length;
    logic                 search_from_start;
  } request_t;

  // Shadow copy of the allocator state, and the results it has yet to see.
  class slot_ledger;
    bit                    occupied [CAPACITY];
    logic [DATA_WIDTH-1:0] contents [CAPACITY];
    int unsigned           hint;
    int unsigned           fill_count;
    int unsigned           failures;
    result_t               due [$];

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      hint       = 0;
      fill_count = 0;
      failures   = 0;
    endfunction

    function bit store_full();
      return occupied[hint];
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void note_request(request_t req);
      result_t r;
      int      i;
      int      first;
      int      last;
      r.status    = ST_OK;
      r.slot      = '0;
      r.read_data = '0;
      case (req.op)
        OP_INSERT: begin
          if (occupied[hint]) begin
            r.status = ST_FULL;
          end else begin
            contents[hint] = req.write_data;
            occupied[hint] = 1'b1;
            fill_count++;
            r.slot = SLOT_W'(hint);
            // With nothing free above, the hint stays on the slot just taken.
            for (i = int'(hint); i < CAPACITY; i++) begin
              if (!occupied[i]) begin
                hint = i;
                break;
              end
            end
          end
        end
        OP_REMOVE: begin
          first = int'(req.slot_index);
          last  = first + int'(req.run_length);
          if (last > CAPACITY) begin
            r.status = ST_RANGE;
          end else if (req.run_length != 0) begin
            if (first < int'(hint) || occupied[hint]) hint = first;
            for (i = first; i < last; i++) begin
              if (occupied[i]) begin
                occupied[i] = 1'b0;
                fill_count--;
              end
            end
          end
        end
        OP_FIND: begin
          first    = req.search_from_start ? 0 : int'(req.slot_index) + 1;
          r.status = ST_NONE;
          for (i = first; i < CAPACITY; i++) begin
            if (occupied[i]) begin
              r.status    = ST_OK;
              r.slot      = SLOT_W'(i);
              r.read_data = contents[i];
              break;
            end
          end
        end
        default: r.status = ST_RANGE;
      endcase
      r.occupied_count = COUNT_W'(fill_count);
      due.push_back(r);
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("%s", what);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result: status %0d slot %0d data %h count %0d",
                       got.status, got.slot, got.read_data, got.occupied_count));
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.read_data !== want.read_data ||
          got.occupied_count !== want.occupied_count)
        flag($sformatf({"mismatch: expected status %0d slot %0d data %h count %0d,",
                        " got status %0d slot %0d data %h count %0d"},
                       want.status, want.slot, want.read_data, want.occupied_count,
                       got.status, got.slot, got.read_data, got.occupied_count));
    endfunction
  endclass

endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import sab_pkg::*;
  import sab_tb_pkg::*;

  // Rough budget: the slowest transaction walks all 32 bitmap rows, and idling on
  // both sides adds to that. The limit is many times the slowest plausible run.
  localparam int RANDOM_ITEMS  = 800;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PERCENT  = 38;
  localparam int SETTLE_CYCLES = 100;

  logic clk;
  logic rst_n;

  sab_in_if  in_chan ();
  sab_out_if out_chan ();

  slot_allocator_with_bitmap dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  slot_ledger  ledger = new();
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned random_goal;
  int unsigned round;
  // While calm is set neither side idles. The receiver compares the two hold
  // counters to learn that a long hold-off has been asked for.
  bit          calm;
  int unsigned hold_requests;
  int unsigned holds_done;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A run that hangs ends here rather than running on forever.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result side: ready changes on the falling edge. Normally it drops at
  // random; a pending hold-off request keeps it low for a fixed stretch so
  // that the block fills up and back-pressures its input.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      if (holds_done != hold_requests) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_chan.ready <= 1'b0;
        end
        holds_done++;
      end else begin
        @(negedge clk);
        out_chan.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      ledger.check_result(result_t'({out_chan.status, out_chan.slot,
                                     out_chan.read_data, out_chan.occupied_count}));
  end

  function automatic request_t request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data,
                                       logic [SLOT_W-1:0] idx, logic [RUN_W-1:0] len,
                                       logic from_start);
    request_t r;
    r.op                = op;
    r.write_data        = data;
    r.slot_index        = idx;
    r.run_length        = len;
    r.search_from_start = from_start;
    return r;
  endfunction

  // Offers one transaction, with random idle cycles in front of it, and
  // records it with the ledger at the edge where it is taken. Each falling
  // edge carries at most one assignment to valid.
  task automatic send(request_t req);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid             <= 1'b1;
    in_chan.op                <= req.op;
    in_chan.write_data        <= req.write_data;
    in_chan.slot_index        <= req.slot_index;
    in_chan.run_length        <= req.run_length;
    in_chan.search_from_start <= req.search_from_start;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    ledger.note_request(req);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic request_t random_insert();
    return request(OP_INSERT, $urandom, SLOT_W'($urandom), RUN_W'($urandom_range(256)),
                   1'($urandom));
  endfunction

  function automatic request_t random_find();
    return request(OP_FIND, $urandom, SLOT_W'($urandom), RUN_W'($urandom_range(256)),
                   $urandom_range(3) == 0);
  endfunction

  // A block of random transactions; the percentages pick the operation and
  // whatever is left over goes to the unused op code.
  task automatic send_mix(int count, int insert_pct, int remove_pct, int find_pct);
    int unsigned roll;
    int unsigned idx;
    int unsigned len;
    repeat (count) begin
      roll = $urandom_range(99);
      idx  = $urandom_range(255);
      if (roll < insert_pct) begin
        send(random_insert());
      end else if (roll < insert_pct + remove_pct) begin
        // Mostly short runs, some that reach to the end of the store, and
        // some of any length, which are often out of range.
        roll = $urandom_range(99);
        if (roll < 60)      len = $urandom_range(8);
        else if (roll < 85) len = $urandom_range(256 - idx);
        else                len = $urandom_range(256);
        send(request(OP_REMOVE, $urandom, SLOT_W'(idx), RUN_W'(len), 1'($urandom)));
      end else if (roll < insert_pct + remove_pct + find_pct) begin
        send(random_find());
      end else begin
        send(request(OP_UNKNOWN, $urandom, SLOT_W'(idx), RUN_W'($urandom_range(256)),
                     1'($urandom)));
      end
    end
  endtask

  initial begin
    rst_n                     = 1'b0;
    in_chan.valid             = 1'b0;
    in_chan.op                = OP_INSERT;
    in_chan.write_data        = '0;
    in_chan.slot_index        = '0;
    in_chan.run_length        = '0;
    in_chan.search_from_start = 1'b0;
    calm                      = 1'b0;
    hold_requests             = 0;
    holds_done                = 0;
    items_sent                = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. On the empty store, finds from the start and from the
    // last slot report nothing, and an empty remove, a remove past the end
    // and the unused op code change nothing.
    send(request(OP_FIND, '0, '0, '0, 1'b1));
    send(request(OP_FIND, '0, 8'd255, '0, 1'b0));
    send(request(OP_REMOVE, '0, '0, '0, 1'b0));
    send(request(OP_REMOVE, '0, 8'd255, 9'd2, 1'b0));
    send(request(OP_UNKNOWN, '1, '1, '1, 1'b1));
    // Three inserts, two of them with extreme data, then finds from various points.
    send(request(OP_INSERT, '0, '0, '0, 1'b0));
    send(request(OP_INSERT, '1, '1, 9'd256, 1'b1));
    send(request(OP_INSERT, 32'hA5A5_5A5A, 8'd17, 9'd3, 1'b0));
    send(request(OP_FIND, '0, 8'd200, '0, 1'b1));
    send(request(OP_FIND, '0, 8'd0, '0, 1'b0));
    send(request(OP_FIND, '0, 8'd1, '0, 1'b0));
    // Freeing the middle slot pulls the hint down, the next insert refills
    // it and the scan then moves the hint past the occupied slots.
    send(request(OP_REMOVE, '0, 8'd1, 9'd1, 1'b0));
    send(request(OP_INSERT, 32'h8000_0001, '0, '0, 1'b0));
    send(request(OP_INSERT, 32'h7FFF_FFFE, '0, '0, 1'b0));
    // A run below the hint pulls the hint down to the run start.
    send(request(OP_REMOVE, '0, 8'd2, 9'd1, 1'b0));
    send(request(OP_FIND, '0, 8'd1, '0, 1'b0));
    // A whole-store remove counts only the slots that were occupied; a
    // second one finds nothing left to free.
    send(request(OP_REMOVE, '0, 8'd0, 9'd256, 1'b0));
    send(request(OP_REMOVE, '0, 8'd0, 9'd256, 1'b0));
    send(request(OP_FIND, '0, '0, '0, 1'b1));
    send(request(OP_INSERT, 32'h0123_4567, '0, '0, 1'b0));
    send(request(OP_REMOVE, '0, 8'd255, 9'd1, 1'b0));
    send(request(OP_REMOVE, '0, 8'd1, 9'd255, 1'b0));
    send(request(OP_REMOVE, '0, 8'd1, 9'd256, 1'b0));
    wait_drained();

    // Random part, in rounds of different character.
    random_goal = items_sent + RANDOM_ITEMS;
    round       = 0;
    while (items_sent < random_goal) begin
      case (round % 5)
        0: send_mix(120, 45, 20, 30);
        1: begin
          // Fill the store to full while the receiver holds off for a long
          // stretch, then keep inserting into the full store, and free short
          // runs while full so that the hint may jump upward.
          hold_requests++;
          while (!ledger.store_full()) begin
            if ($urandom_range(99) < 15) send(random_find());
            else                         send(random_insert());
          end
          repeat (3) send(random_insert());
          repeat (3) begin
            send(request(OP_REMOVE, $urandom, SLOT_W'($urandom_range(252)),
                         RUN_W'($urandom_range(4, 1)), 1'($urandom)));
            send(random_insert());
            send(random_insert());
          end
          wait_drained();
        end
        2: send_mix(100, 15, 50, 30);
        3: begin
          calm = 1'b1;
          send_mix(100, 45, 20, 30);
          calm = 1'b0;
        end
        default: send_mix(100, 60, 15, 20);
      endcase
      round++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sab_pkg.sv
hdl/sab_if.sv
hdl/sab_ram.sv
hdl/sab_bitmap.sv
hdl/sab_ctrl.sv
hdl/slot_allocator_with_bitmap.sv
tb/sv/sab_tb_pkg.sv
tb/sv/testbench.sv
